[hw/rtl/glb_container_deframer_macros.svh]
// Assertion macros for the deframer RTL.
`ifndef GLB_CONTAINER_DEFRAMER_MACROS_SVH
`define GLB_CONTAINER_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GLBDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glbdf same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GLBDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glbdf next-cycle check failed");

`endif

[hw/rtl/glbdf_pkg.sv]
// Types and constants of the GLB container deframer.
`default_nettype none

package glbdf_pkg;

    localparam logic [31:0] GLB_MAGIC    = 32'h4654_6C67;
    localparam logic [31:0] TYPE_JSON    = 32'h4E4F_534A;
    localparam logic [31:0] TYPE_BIN     = 32'h004E_4942;
    localparam int          HEADER_BYTES = 12;
    localparam int          MAX_RESULTS  = 4;
    localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_DETECT = 2'd0,
        MODE_TEXT   = 2'd1,
        MODE_HEADER = 2'd2,
        MODE_CHUNKS = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CLASS_HEADER = 2'd0,
        CLASS_JSON   = 2'd1,
        CLASS_BIN    = 2'd2,
        CLASS_OTHER  = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_JSON   = 2'd1,
        KIND_BIN    = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_RUNNING = 3'd0,
        ST_TEXT    = 3'd1,
        ST_OK      = 3'd2,
        ST_SHORT   = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_OVERRUN = 3'd5,
        ST_NO_JSON = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       start;
        logic       endm;
        status_t    status;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/glb_container_deframer.sv]
// Top level of the GLB container deframer: byte stream in, tagged payload out.
//
//   channel | handshake         | payload
//   in      | in_valid/in_stall | data_byte, last_byte
//   out     | out_valid/out_stall | out_byte, out_kind, chunk_start, end_mark, status
//
// One byte is worked per cycle from the input register into a four-entry result buffer
// when it is empty or its last result leaves; items of at most one result sustain this
// while out_stall is low, and an item releasing the held magic bytes holds the next back.
// An input register lets one byte be taken while results still wait at the output.
// Reset clears all control state; after the final byte the parser returns to reset state.
`default_nettype none

module glb_container_deframer
    import glbdf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [1:0]      out_kind,
    output logic            chunk_start,
    output logic            end_mark,
    output logic [2:0]      status
);

`include "glb_container_deframer_macros.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    mode_t       mode_reg, mode_next;
    logic [32:0] pos_reg, pos_next;
    logic [31:0] held_reg, held_next;
    logic [31:0] total_reg, total_next;
    logic [55:0] hdr_reg, hdr_next;
    logic [32:0] cend_reg, cend_next;
    class_t      class_reg, class_next;
    logic        json_reg, json_next;
    logic        ovr_reg, ovr_next;
    logic        first_reg, first_next;

    res_t        buf_reg [MAX_RESULTS];
    res_t        res     [MAX_RESULTS];
    logic [2:0]  cnt_reg, cnt_next;

    logic        in_accept;
    logic        pop;
    logic        proc;

    logic [33:0] pos34;
    logic [33:0] total34;
    logic [33:0] pos_p1;
    logic [33:0] pos_p8;
    logic [33:0] endsum;
    logic [1:0]  p;
    logic [2:0]  idx;
    logic        magic_hit;
    logic        at_hdr_start;
    logic [31:0] ctype;
    logic [2:0]  n_emit;
    status_t     st_final;

    assign pop       = (cnt_reg != 3'd0) && !out_stall;
    assign proc      = in_valid_reg && ((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && pop));
    assign in_stall  = in_valid_reg && !proc;
    assign in_accept = in_valid && !in_stall;

    assign pos34        = {1'b0, pos_reg};
    assign total34      = {2'b00, total_reg};
    assign pos_p1       = pos34 + 34'd1;
    assign pos_p8       = pos34 + 34'd8;
    assign endsum       = pos_p1 + {2'b00, hdr_reg[31:0]};
    assign p            = pos_reg[1:0];
    assign idx          = pos_reg[2:0] - cend_reg[2:0];
    assign at_hdr_start = (pos_reg == cend_reg);
    assign ctype        = {in_byte_reg, hdr_reg[55:32]};

    always_comb
    begin
        held_next = held_reg;
        held_next[{p, 3'b000} +: 8] = in_byte_reg;
    end

    assign magic_hit = (held_next == GLB_MAGIC);

    // next mode
    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            MODE_DETECT:
            begin
                if (p == 2'd3)
                begin
                    mode_next = magic_hit ? MODE_HEADER : MODE_TEXT;
                end
            end
            MODE_TEXT:
            begin
                mode_next = MODE_TEXT;
            end
            MODE_HEADER:
            begin
                if (pos_p1 >= 34'(HEADER_BYTES))
                begin
                    mode_next = MODE_CHUNKS;
                end
            end
            MODE_CHUNKS:
            begin
                mode_next = MODE_CHUNKS;
            end
            default:
            begin
                mode_next = MODE_DETECT;
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        total_next = total_reg;
        hdr_next   = hdr_reg;
        cend_next  = cend_reg;
        class_next = class_reg;
        json_next  = json_reg;
        ovr_next   = ovr_reg;
        first_next = first_reg;
        n_emit     = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res[i] = '{data: in_byte_reg, kind: KIND_TEXT, start: 1'b0,
                       endm: 1'b0, status: ST_RUNNING};
        end

        unique case (mode_reg)
            MODE_DETECT:
            begin
                for (int i = 0; i < MAX_RESULTS; i++)
                begin
                    res[i].data = held_next[8*i +: 8];
                end
                if (p == 2'd3)
                begin
                    if (!magic_hit)
                    begin
                        n_emit = 3'd4;
                    end
                end
                else if (in_last_reg)
                begin
                    n_emit = {1'b0, p} + 3'd1;
                end
            end
            MODE_TEXT:
            begin
                n_emit = 3'd1;
            end
            MODE_HEADER:
            begin
                if (pos_reg >= 33'd8)
                begin
                    total_next[{p, 3'b000} +: 8] = in_byte_reg;
                end
                if (pos_p1 >= 34'(HEADER_BYTES))
                begin
                    class_next = CLASS_HEADER;
                    cend_next  = 33'(HEADER_BYTES);
                    hdr_next   = '0;
                end
            end
            MODE_CHUNKS:
            begin
                if (!ovr_reg && (pos34 < total34))
                begin
                    if (class_reg == CLASS_HEADER)
                    begin
                        if (at_hdr_start && (pos_p8 > total34))
                        begin
                            cend_next = pos_p1[32:0];
                        end
                        else if (idx != 3'd7)
                        begin
                            hdr_next[{idx, 3'b000} +: 8] = in_byte_reg;
                        end
                        else
                        begin
                            hdr_next = '0;
                            if (endsum > total34)
                            begin
                                ovr_next = 1'b1;
                            end
                            else
                            begin
                                cend_next  = endsum[32:0];
                                first_next = 1'b1;
                                if (ctype == TYPE_JSON)
                                begin
                                    class_next = CLASS_JSON;
                                    json_next  = 1'b1;
                                end
                                else if (ctype == TYPE_BIN)
                                begin
                                    class_next = CLASS_BIN;
                                end
                                else
                                begin
                                    class_next = CLASS_OTHER;
                                end
                                if (hdr_reg[31:0] == 32'd0)
                                begin
                                    class_next = CLASS_HEADER;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (class_reg == CLASS_JSON || class_reg == CLASS_BIN)
                        begin
                            n_emit       = 3'd1;
                            res[0].kind  = (class_reg == CLASS_JSON) ? KIND_JSON : KIND_BIN;
                            res[0].start = first_reg;
                        end
                        first_next = 1'b0;
                        if (pos_p1 >= {1'b0, cend_reg})
                        begin
                            class_next = CLASS_HEADER;
                            hdr_next   = '0;
                        end
                    end
                end
            end
            default:
            begin
                n_emit = 3'd0;
            end
        endcase

        if (mode_next == MODE_DETECT || mode_next == MODE_TEXT)
        begin
            st_final = ST_TEXT;
        end
        else if (mode_next == MODE_HEADER)
        begin
            st_final = ST_SHORT;
        end
        else if ({2'b00, total_next} > pos_p1)
        begin
            st_final = ST_TRUNC;
        end
        else if (ovr_next)
        begin
            st_final = ST_OVERRUN;
        end
        else if (!json_next)
        begin
            st_final = ST_NO_JSON;
        end
        else
        begin
            st_final = ST_OK;
        end

        cnt_next = n_emit;
        if (in_last_reg)
        begin
            if (n_emit == 3'd0)
            begin
                res[0] = '{data: 8'h00, kind: KIND_STATUS, start: 1'b0,
                           endm: 1'b0, status: ST_RUNNING};
                cnt_next = 3'd1;
            end
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                if (3'(i) == cnt_next - 3'd1)
                begin
                    res[i].endm   = 1'b1;
                    res[i].status = st_final;
                end
            end
        end

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_p1[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cnt_reg      <= 3'd0;
            mode_reg     <= MODE_DETECT;
            pos_reg      <= '0;
            held_reg     <= '0;
            total_reg    <= '0;
            hdr_reg      <= '0;
            cend_reg     <= '0;
            class_reg    <= CLASS_HEADER;
            json_reg     <= 1'b0;
            ovr_reg      <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                cnt_reg <= cnt_next;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end

            if (proc)
            begin
                if (in_last_reg)
                begin
                    mode_reg  <= MODE_DETECT;
                    pos_reg   <= '0;
                    held_reg  <= '0;
                    total_reg <= '0;
                    hdr_reg   <= '0;
                    cend_reg  <= '0;
                    class_reg <= CLASS_HEADER;
                    json_reg  <= 1'b0;
                    ovr_reg   <= 1'b0;
                    first_reg <= 1'b0;
                end
                else
                begin
                    mode_reg  <= mode_next;
                    pos_reg   <= pos_next;
                    held_reg  <= (mode_reg == MODE_DETECT) ? held_next : held_reg;
                    total_reg <= total_next;
                    hdr_reg   <= hdr_next;
                    cend_reg  <= cend_next;
                    class_reg <= class_next;
                    json_reg  <= json_next;
                    ovr_reg   <= ovr_next;
                    first_reg <= first_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (proc)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_reg[i] <= res[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    assign out_valid   = (cnt_reg != 3'd0);
    assign out_byte    = buf_reg[0].data;
    assign out_kind    = buf_reg[0].kind;
    assign chunk_start = buf_reg[0].start;
    assign end_mark    = buf_reg[0].endm;
    assign status      = buf_reg[0].status;

    `GLBDF_ASSERT_NOW(a_end_is_tail, out_valid && end_mark, cnt_reg == 3'd1)
    `GLBDF_ASSERT_NOW(a_status_only, out_valid && out_kind == KIND_STATUS,
        out_byte == 8'h00 && end_mark)
    `GLBDF_ASSERT_NOW(a_start_payload, out_valid && chunk_start,
        out_kind == KIND_JSON || out_kind == KIND_BIN)
    `GLBDF_ASSERT_NEXT(a_file_restart, proc && in_last_reg,
        mode_reg == MODE_DETECT && pos_reg == 33'd0)
    `GLBDF_ASSERT_NOW(a_proc_room, proc, cnt_reg == 3'd0 || (cnt_reg == 3'd1 && pop))

endmodule

`default_nettype wire
